// ===== rtl/core/nfu_pkg.sv =====
// nfu_pkg: shared constants and types for the nfu page replacement block
// no dependencies; imported by nfu_cmp, nfu_page_replacement and tb
package nfu_pkg;

    localparam int CFG_BITS   = 5;
    localparam int SLOT_BITS  = 4;
    localparam int FAULT_BITS = 32;
    localparam int DATA_BITS  = 32;
    localparam int ADDR_BITS  = 3;

    // register index, taken from paddr[2]
    localparam logic REG_FRAMES_IN_USE = 1'b0;

    localparam logic [CFG_BITS-1:0] FRAMES_IN_USE_RESET = 5'd16;

    typedef struct packed {
        logic clear;
        logic match_en;
        logic min_en;
    } cmp_ctrl_t;

endpackage

// ===== rtl/core/nfu_ram.sv =====
// nfu_ram: generic single-write, single-read ram with registered read data
// no dependencies
module nfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/nfu_cmp.sv =====
// nfu_cmp: shared compare unit, hit match and running minimum over the frame scan
// depends on nfu_pkg (cmp_ctrl_t)
module nfu_cmp
    import nfu_pkg::*;
#(
    parameter int IDX_BITS   = 4,
    parameter int PAGE_BITS  = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmp_ctrl_t             ctrl,
    input  logic [PAGE_BITS-1:0]  pg,
    input  logic [PAGE_BITS-1:0]  frame_page,
    input  logic [IDX_BITS-1:0]   frame_idx,
    input  logic [COUNT_BITS-1:0] count,
    output logic                  hit,
    output logic [IDX_BITS-1:0]   hit_idx,
    output logic [IDX_BITS-1:0]   best_idx,
    output logic [PAGE_BITS-1:0]  best_page
);

    logic                  hit_reg,       hit_next;
    logic [IDX_BITS-1:0]   hit_idx_reg,   hit_idx_next;
    logic [PAGE_BITS-1:0]  s2_page_reg,   s2_page_next;
    logic [IDX_BITS-1:0]   s2_idx_reg,    s2_idx_next;
    logic                  have_reg,      have_next;
    logic [COUNT_BITS-1:0] best_cnt_reg,  best_cnt_next;
    logic [IDX_BITS-1:0]   best_idx_reg,  best_idx_next;
    logic [PAGE_BITS-1:0]  best_page_reg, best_page_next;

    always_comb
    begin
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        s2_page_next   = s2_page_reg;
        s2_idx_next    = s2_idx_reg;
        have_next      = have_reg;
        best_cnt_next  = best_cnt_reg;
        best_idx_next  = best_idx_reg;
        best_page_next = best_page_reg;
        if (ctrl.clear)
        begin
            hit_next  = 1'b0;
            have_next = 1'b0;
        end
        if (ctrl.match_en)
        begin
            s2_page_next = frame_page;
            s2_idx_next  = frame_idx;
            if (frame_page == pg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = frame_idx;
            end
        end
        // strict compare keeps the lowest frame on ties
        if (ctrl.min_en && (!have_reg || (count < best_cnt_reg)))
        begin
            have_next      = 1'b1;
            best_cnt_next  = count;
            best_idx_next  = s2_idx_reg;
            best_page_next = s2_page_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            s2_page_reg   <= '0;
            s2_idx_reg    <= '0;
            have_reg      <= 1'b0;
            best_cnt_reg  <= '0;
            best_idx_reg  <= '0;
            best_page_reg <= '0;
        end
        else
        begin
            hit_reg       <= hit_next;
            hit_idx_reg   <= hit_idx_next;
            s2_page_reg   <= s2_page_next;
            s2_idx_reg    <= s2_idx_next;
            have_reg      <= have_next;
            best_cnt_reg  <= best_cnt_next;
            best_idx_reg  <= best_idx_next;
            best_page_reg <= best_page_next;
        end
    end

    assign hit       = hit_reg;
    assign hit_idx   = hit_idx_reg;
    assign best_idx  = best_idx_reg;
    assign best_page = best_page_reg;

endmodule

// ===== rtl/core/nfu_page_replacement.sv =====
// nfu_page_replacement: not-frequently-used page replacement, sequencer and config port
// depends on nfu_pkg, nfu_ram (frame and count tables), nfu_cmp (scan compare unit)
// an item runs from start through the frame scan over the occupied frames, one frame read per
// cycle through the frame ram and count ram, to the update state; busy is high until it ends,
// so a new start waits; done is registered from the update state; the receiver cannot stall
// results; after reset the count table is cleared, one entry per cycle, over all 2^PAGE_BITS
// entries with busy high; config writes are taken during that pass
module nfu_page_replacement
    import nfu_pkg::*;
#(
    parameter int FRAMES     = 16,
    parameter int PAGE_BITS  = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  logic [PAGE_BITS-1:0]  page,
    output logic                  done,
    output logic                  hit,
    output logic [SLOT_BITS-1:0]  frame_slot,
    output logic                  evicted_valid,
    output logic [PAGE_BITS-1:0]  evicted_page,
    output logic [FAULT_BITS-1:0] fault_total
);

    localparam int IDX_BITS  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FILL_BITS = $clog2(FRAMES + 1);
    localparam int CAP_BITS  = (FILL_BITS > CFG_BITS) ? FILL_BITS : CFG_BITS;
    localparam int SW        = (IDX_BITS > SLOT_BITS) ? IDX_BITS : SLOT_BITS;
    localparam int PAGES     = 1 << PAGE_BITS;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t                state_reg,    state_next;
    logic [PAGE_BITS-1:0]  clr_reg,      clr_next;
    logic [CFG_BITS-1:0]   cfg_reg,      cfg_next;
    logic [PAGE_BITS-1:0]  pg_reg,       pg_next;
    logic [FILL_BITS-1:0]  filled_reg,   filled_next;
    logic [FILL_BITS-1:0]  idx_reg,      idx_next;
    logic                  v1_reg,       v1_next;
    logic                  v2_reg,       v2_next;
    logic [IDX_BITS-1:0]   idx1_reg,     idx1_next;
    logic [FAULT_BITS-1:0] fault_reg,    fault_next;
    logic                  done_reg,     done_next;
    logic                  hit_reg,      hit_next;
    logic [SLOT_BITS-1:0]  slot_reg,     slot_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic [PAGE_BITS-1:0]  ev_page_reg,  ev_page_next;

    logic                  cfg_wr;
    logic [CAP_BITS-1:0]   cfg_w;
    logic [CAP_BITS-1:0]   frames_w;
    logic [CAP_BITS-1:0]   cap_w;
    logic                  room;
    logic                  accept;
    logic                  issue;

    logic                  frame_we;
    logic [IDX_BITS-1:0]   frame_waddr;
    logic [PAGE_BITS-1:0]  frame_rdata;
    logic                  count_we;
    logic [PAGE_BITS-1:0]  count_waddr;
    logic [COUNT_BITS-1:0] count_wdata;
    logic [PAGE_BITS-1:0]  count_raddr;
    logic [COUNT_BITS-1:0] count_rdata;

    cmp_ctrl_t             cmp_ctrl;
    logic                  cmp_hit;
    logic [IDX_BITS-1:0]   cmp_hit_idx;
    logic [IDX_BITS-1:0]   cmp_best_idx;
    logic [PAGE_BITS-1:0]  cmp_best_page;
    logic [IDX_BITS-1:0]   slot_idx;
    logic [SW-1:0]         slot_ext;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ? DATA_BITS'(cfg_reg) : '0;

    // effective capacity, clamped to 1..FRAMES
    assign cfg_w    = CAP_BITS'(cfg_reg);
    assign frames_w = CAP_BITS'(FRAMES);
    assign cap_w    = (cfg_w == '0) ? CAP_BITS'(1) : ((cfg_w > frames_w) ? frames_w : cfg_w);
    assign room     = CAP_BITS'(filled_reg) < cap_w;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign issue  = (state_reg == ST_SCAN) && (idx_reg < filled_reg);

    assign cmp_ctrl.clear    = accept;
    assign cmp_ctrl.match_en = v1_reg;
    assign cmp_ctrl.min_en   = v2_reg;

    // second read stage looks up the count of the page just read
    assign count_raddr = v1_reg ? frame_rdata : pg_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cfg_next      = cfg_reg;
        pg_next       = pg_reg;
        filled_next   = filled_reg;
        idx_next      = idx_reg;
        v1_next       = issue;
        v2_next       = v1_reg;
        idx1_next     = idx1_reg;
        fault_next    = fault_reg;
        done_next     = 1'b0;
        hit_next      = hit_reg;
        slot_next     = slot_reg;
        ev_valid_next = ev_valid_reg;
        ev_page_next  = ev_page_reg;
        frame_we      = 1'b0;
        frame_waddr   = filled_reg[IDX_BITS-1:0];
        count_we      = 1'b0;
        count_waddr   = pg_reg;
        count_wdata   = COUNT_BITS'(1);
        slot_idx      = cmp_hit_idx;

        if (cfg_wr && (paddr[2] == REG_FRAMES_IN_USE))
        begin
            cfg_next = pwdata[CFG_BITS-1:0];
        end

        if (issue)
        begin
            idx_next  = idx_reg + FILL_BITS'(1);
            idx1_next = idx_reg[IDX_BITS-1:0];
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                count_we    = 1'b1;
                count_waddr = clr_reg;
                count_wdata = '0;
                clr_next    = clr_reg + PAGE_BITS'(1);
                if (clr_reg == PAGE_BITS'(PAGES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    pg_next    = page;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issue && !v1_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                done_next     = 1'b1;
                hit_next      = cmp_hit;
                ev_valid_next = 1'b0;
                ev_page_next  = '0;
                if (cmp_hit)
                begin
                    slot_idx    = cmp_hit_idx;
                    count_we    = (count_rdata != '1);
                    count_wdata = count_rdata + COUNT_BITS'(1);
                end
                else
                begin
                    if (fault_reg != '1)
                    begin
                        fault_next = fault_reg + FAULT_BITS'(1);
                    end
                    frame_we    = 1'b1;
                    count_we    = (count_rdata == '0);
                    count_wdata = COUNT_BITS'(1);
                    if (room)
                    begin
                        slot_idx    = filled_reg[IDX_BITS-1:0];
                        filled_next = filled_reg + FILL_BITS'(1);
                    end
                    else
                    begin
                        slot_idx      = cmp_best_idx;
                        ev_valid_next = 1'b1;
                        ev_page_next  = cmp_best_page;
                    end
                    frame_waddr = slot_idx;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        slot_ext = SW'(slot_idx);
        if (state_reg == ST_UPDATE)
        begin
            slot_next = slot_ext[SLOT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            cfg_reg      <= FRAMES_IN_USE_RESET;
            pg_reg       <= '0;
            filled_reg   <= '0;
            idx_reg      <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            idx1_reg     <= '0;
            fault_reg    <= '0;
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            slot_reg     <= '0;
            ev_valid_reg <= 1'b0;
            ev_page_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            cfg_reg      <= cfg_next;
            pg_reg       <= pg_next;
            filled_reg   <= filled_next;
            idx_reg      <= idx_next;
            v1_reg       <= v1_next;
            v2_reg       <= v2_next;
            idx1_reg     <= idx1_next;
            fault_reg    <= fault_next;
            done_reg     <= done_next;
            hit_reg      <= hit_next;
            slot_reg     <= slot_next;
            ev_valid_reg <= ev_valid_next;
            ev_page_reg  <= ev_page_next;
        end
    end

    nfu_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAMES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (pg_reg),
        .raddr (idx_reg[IDX_BITS-1:0]),
        .rdata (frame_rdata)
    );

    nfu_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (PAGES)
    ) u_count_ram (
        .clk   (clk),
        .we    (count_we),
        .waddr (count_waddr),
        .wdata (count_wdata),
        .raddr (count_raddr),
        .rdata (count_rdata)
    );

    nfu_cmp #(
        .IDX_BITS   (IDX_BITS),
        .PAGE_BITS  (PAGE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_cmp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (cmp_ctrl),
        .pg         (pg_reg),
        .frame_page (frame_rdata),
        .frame_idx  (idx1_reg),
        .count      (count_rdata),
        .hit        (cmp_hit),
        .hit_idx    (cmp_hit_idx),
        .best_idx   (cmp_best_idx),
        .best_page  (cmp_best_page)
    );

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign frame_slot    = slot_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_total   = fault_reg;

    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == ST_UPDATE)
        else $error("result beat without an update cycle");

    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= FILL_BITS'(FRAMES))
        else $error("occupied frame count above frame total");

    a_start_scans: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> state_reg == ST_SCAN)
        else $error("accepted beat did not start a scan");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && evicted_valid))
        else $error("eviction reported on a hit");

    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> state_reg == ST_SCAN)
        else $error("scan pipeline active outside the scan");

endmodule

// ===== verif/tb.sv =====
// tb: self-checking testbench for nfu_page_replacement, page references in, hit/fault results out
// depends on nfu_pkg and the nfu_page_replacement rtl; a tracker class predicts each result beat
`timescale 1ns / 100ps

module tb;
    import nfu_pkg::*;

    localparam int PAGE_W    = 8;
    localparam int FRAME_CNT = 16;
    localparam int COUNT_W   = 16;
    localparam int SCAN_SLACK = FRAME_CNT + 8;

    localparam logic [ADDR_BITS-1:0] FRAMES_ADDR = {REG_FRAMES_IN_USE, 2'b00};
    localparam logic [ADDR_BITS-1:0] SPARE_ADDR  = 3'b100;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_BITS-1:0]  slot;
        logic                  evicted;
        logic [PAGE_W-1:0]     victim;
        logic [FAULT_BITS-1:0] faults;
    } page_outcome_t;

    class page_ref_tracker;
        logic [CFG_BITS-1:0]   frames_cfg;
        logic [PAGE_W-1:0]     frame_tab [FRAME_CNT];
        int unsigned           filled;
        logic [COUNT_W-1:0]    counts [1 << PAGE_W];
        logic [FAULT_BITS-1:0] faults;
        page_outcome_t         pending[$];
        int unsigned           errors;

        function new();
            frames_cfg = FRAMES_IN_USE_RESET;
            filled = 0;
            faults = '0;
            errors = 0;
            foreach (counts[i]) counts[i] = '0;
            foreach (frame_tab[i]) frame_tab[i] = '0;
        endfunction

        function int unsigned capacity();
            if (frames_cfg == 0)
                return 1;
            if (frames_cfg > FRAME_CNT)
                return FRAME_CNT;
            return frames_cfg;
        endfunction

        function void set_frames(logic [CFG_BITS-1:0] value);
            frames_cfg = value;
        endfunction

        function void note_reference(logic [PAGE_W-1:0] pg);
            page_outcome_t      want;
            bit                 found;
            int unsigned        best;
            logic [COUNT_W-1:0] best_cnt;
            want = '0;
            found = 0;
            for (int i = 0; i < filled; i++)
            begin
                if (!found && frame_tab[i] == pg)
                begin
                    found = 1;
                    want.slot = SLOT_BITS'(i);
                end
            end
            if (found)
            begin
                want.hit = 1'b1;
                if (counts[pg] != '1)
                    counts[pg] = counts[pg] + 1'b1;
            end
            else
            begin
                if (faults != '1)
                    faults = faults + 1'b1;
                if (filled < capacity())
                begin
                    want.slot = SLOT_BITS'(filled);
                    frame_tab[filled] = pg;
                    filled++;
                end
                else
                begin
                    best = 0;
                    best_cnt = counts[frame_tab[0]];
                    for (int i = 1; i < filled; i++)
                    begin
                        if (counts[frame_tab[i]] < best_cnt)
                        begin
                            best_cnt = counts[frame_tab[i]];
                            best = i;
                        end
                    end
                    want.slot = SLOT_BITS'(best);
                    want.evicted = 1'b1;
                    want.victim = frame_tab[best];
                    frame_tab[best] = pg;
                end
                if (counts[pg] == '0)
                    counts[pg] = COUNT_W'(1);
            end
            want.faults = faults;
            pending = {pending, want};
        endfunction

        function void compare_field(string label, logic [FAULT_BITS-1:0] want,
                                    logic [FAULT_BITS-1:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
            end
        endfunction

        function void check_outcome(page_outcome_t got);
            page_outcome_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected, got hit %0b slot %0d",
                         $time, got.hit, got.slot);
                return;
            end
            want = pending.pop_front();
            compare_field("hit", FAULT_BITS'(want.hit), FAULT_BITS'(got.hit));
            compare_field("frame_slot", FAULT_BITS'(want.slot), FAULT_BITS'(got.slot));
            compare_field("evicted_valid", FAULT_BITS'(want.evicted), FAULT_BITS'(got.evicted));
            compare_field("evicted_page", FAULT_BITS'(want.victim), FAULT_BITS'(got.victim));
            compare_field("fault_total", want.faults, got.faults);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic [PAGE_W-1:0] page = '0;
    logic done;
    logic hit;
    logic [SLOT_BITS-1:0] frame_slot;
    logic evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic [FAULT_BITS-1:0] fault_total;

    page_ref_tracker tracker = new();
    logic [PAGE_W-1:0] hot_base = '0;

    logic [PAGE_W-1:0] shrink_refs [4] = '{8'h55, 8'h00, 8'hFF, 8'h55};
    logic [PAGE_W-1:0] fill_refs [19] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
                                          8'h80, 8'h01, 8'hFE, 8'h7F, 8'hC0, 8'hC1, 8'hC2,
                                          8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7};
    logic [CFG_BITS-1:0] cfg_plan [9] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd7, 5'd16,
                                          5'd2, 5'd20, 5'd12};
    int unsigned idle_pct [3] = '{6, 81, 0};

    nfu_page_replacement dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .page          (page),
        .done          (done),
        .hit           (hit),
        .frame_slot    (frame_slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_outcome(page_outcome_t'{hit, frame_slot, evicted_valid,
                                                  evicted_page, fault_total});
    end

    task automatic reg_write(input logic [ADDR_BITS-1:0] addr, input logic [CFG_BITS-1:0] value);
        logic [DATA_BITS-1:0] word;
        word = $urandom;
        word[CFG_BITS-1:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr[2] == REG_FRAMES_IN_USE)
            tracker.set_frames(word[CFG_BITS-1:0]);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_readback();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= FRAMES_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== DATA_BITS'(tracker.frames_cfg))
        begin
            tracker.errors++;
            $display("%0t: frames_in_use readback mismatch, expected %0d, got %0d",
                     $time, tracker.frames_cfg, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_page(input logic [PAGE_W-1:0] pg);
        start <= 1'b1;
        page <= pg;
        do @(posedge clk); while (busy);
        tracker.note_reference(pg);
    endtask

    task automatic pause(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SCAN_SLACK) @(posedge clk);
    endtask

    function automatic logic [PAGE_W-1:0] pick_page();
        int unsigned span;
        span = tracker.capacity() + tracker.capacity() / 2;
        if ($urandom_range(99) < 3)
            hot_base = PAGE_W'($urandom);
        if ($urandom_range(99) < 15)
            return PAGE_W'($urandom);
        return hot_base + PAGE_W'($urandom_range(span, 0));
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // two resident pages with uneven counts, then a fault picks between them
        reg_write(FRAMES_ADDR, 5'd2);
        reg_readback();
        send_page(8'h00);
        send_page(8'hFF);
        repeat (20) send_page(8'h00);
        repeat (25) send_page(8'hFF);
        send_page(8'hAA);
        drain();

        // capacity below the occupied frames, re-fault of evicted pages
        reg_write(FRAMES_ADDR, 5'd0);
        reg_readback();
        foreach (shrink_refs[i])
            send_page(shrink_refs[i]);
        drain();
        reg_write(SPARE_ADDR, 5'd16);
        reg_readback();
        send_page(8'h33);
        drain();

        reg_write(FRAMES_ADDR, 5'd31);
        reg_readback();
        foreach (fill_refs[i])
            send_page(fill_refs[i]);
        drain();
        reg_write(FRAMES_ADDR, 5'd17);
        reg_readback();

        for (int ph = 0; ph < 3; ph++)
        begin
            for (int sub = 0; sub < 3; sub++)
            begin
                drain();
                reg_write(FRAMES_ADDR, cfg_plan[ph * 3 + sub]);
                reg_readback();
                for (int n = 0; n < 110; n++)
                begin
                    send_page(pick_page());
                    if ($urandom_range(99) < idle_pct[ph])
                        pause($urandom_range(30, 1));
                    else if ($urandom_range(99) == 0)
                        drain();
                end
            end
        end
        drain();

        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
